>>> sv/uwm_pkg.sv
package uwm_pkg;

  // Window length in samples and derived widths.
  localparam int WINDOW     = 3600;
  localparam int POS_W      = $clog2(WINDOW);
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int USG_W      = 15;
  localparam int FULL_SCALE = 25600;
  localparam int TOT_W      = $clog2(WINDOW * FULL_SCALE + 1);
  localparam int TICK_W     = 32;
  localparam int TPP_W      = 8;
  localparam int TPP_RESET  = 4;
  localparam int PCT_FULL   = 100;
  localparam int FRAC_W     = 8;

  // Shared divider: the usage quotient dividend is delta * 256 with delta below 25600.
  localparam int USG_DVD_W  = USG_W + FRAC_W;
  localparam int DVD_W      = (TOT_W > USG_DVD_W) ? TOT_W : USG_DVD_W;
  localparam int DVS_W      = (CNT_W > TPP_W) ? CNT_W : TPP_W;
  localparam int DIV_CNT_W  = $clog2(DVD_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_U,
    ST_UPDATE,
    ST_START_A,
    ST_DIV_A,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic store_baseline;
    logic usage_zero;
    logic div_start;
    logic div_avg;
    logic usage_load;
    logic update;
    logic avg_load;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic have_baseline;
    logic sat;
    logic div_busy;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

>>> sv/utilization_window_monitor.sv
// Each accepted beat takes two passes of the shared 27-step restoring divider (usage
// quotient, then window average) before out_tvalid; the first pass is skipped when usage
// saturates, and the first reading only sets the baseline and runs no division. One beat
// at a time: in_tready stays low until its result is loaded into the output register; a result
// waiting in the output register does not hold off the next beat. Reset (rst_n, synchronous)
// clears control state, peak, totals and counts; the sample ring needs no clearing pass.
module utilization_window_monitor
  import uwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,  // ticks_per_percent
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] idle_ticks
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [14:0] usage, [29:15] peak_usage,
                                  // [44:30] window_average, [47:45] zero
  output logic        out_tuser   // valid_res
);

  cmd_t             cmd;
  sts_t             sts;
  logic [USG_W-1:0] usage;
  logic [USG_W-1:0] peak;
  logic [USG_W-1:0] avg;

  uwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  uwm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .reading    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_flag   (out_tuser),
    .out_usage  (usage),
    .out_peak   (peak),
    .out_avg    (avg)
  );

  assign out_tdata = {3'b000, avg, peak, usage};

  // The divider is never restarted while a division is still running.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |-> !sts.out_busy)
    else $error("output register overwritten");

  // One item at a time: after an accepted beat the input stays closed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat accepted while busy");

  // A baseline-only result carries all-zero usage fields.
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 48'd0))
    else $error("baseline result carries nonzero fields");

endmodule

>>> sv/uwm_div.sv
module uwm_div
  import uwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DVD_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]     q_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W:0]       shifted;
  logic [DVS_W:0]       diff;
  logic                 take;
  logic [DVS_W-1:0]     rem_nxt;

  // One restoring step per cycle, quotient bits shift in from the bottom.
  always_comb begin
    shifted = {rem_r, q_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    take    = (shifted >= {1'b0, dvs_r});
    rem_nxt = take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], take};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> sv/uwm_datapath.sv
module uwm_datapath
  import uwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [TPP_W-1:0]  cfg_wdata,
  input  logic [TICK_W-1:0] reading,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic              out_flag,
  output logic [USG_W-1:0]  out_usage,
  output logic [USG_W-1:0]  out_peak,
  output logic [USG_W-1:0]  out_avg
);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
  localparam logic [USG_W-1:0] FS       = USG_W'(FULL_SCALE);

  logic [TPP_W-1:0]  tpp_r;
  logic [TICK_W-1:0] reading_r;
  logic [TICK_W-1:0] delta_r;
  logic [TICK_W-1:0] baseline_r;
  logic              have_base_r;
  logic [USG_W-1:0]  peak_r;
  logic [USG_W-1:0]  usage_r;
  logic [USG_W-1:0]  avg_r;
  logic              res_valid_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  held_r;
  logic [TOT_W-1:0]  total_r;
  logic [USG_W-1:0]  ring_rd_r;
  logic              out_valid_r;
  logic              out_flag_r;
  logic [USG_W-1:0]  out_usage_r;
  logic [USG_W-1:0]  out_peak_r;
  logic [USG_W-1:0]  out_avg_r;

  logic [USG_W-1:0]  ring [WINDOW];

  logic [TPP_W-1:0]  tpp_eff;
  logic [USG_W-1:0]  sat_lim;
  logic              full;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_busy;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;

  always_comb begin
    tpp_eff = (tpp_r == '0) ? TPP_W'(1) : tpp_r;
    // The quotient reaches full scale exactly when delta >= 100 * ticks_per_percent.
    sat_lim = USG_W'(PCT_FULL * tpp_eff);
    full    = (held_r == CNT_FULL);
    if (cmd.div_avg) begin
      div_dvd = DVD_W'(total_r);
      div_dvs = DVS_W'(held_r);
    end else begin
      div_dvd = DVD_W'({delta_r[USG_W-1:0], {FRAC_W{1'b0}}});
      div_dvs = DVS_W'(tpp_eff);
    end
  end

  uwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r       <= TPP_W'(TPP_RESET);
      baseline_r  <= '0;
      have_base_r <= 1'b0;
      peak_r      <= '0;
      pos_r       <= '0;
      held_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tpp_r <= cfg_wdata;
      end
      if (cmd.store_baseline) begin
        baseline_r  <= reading_r;
        have_base_r <= 1'b1;
      end
      if (cmd.update) begin
        if (usage_r > peak_r) begin
          peak_r <= usage_r;
        end
        if (full) begin
          total_r <= total_r - TOT_W'(ring_rd_r) + TOT_W'(usage_r);
        end else begin
          total_r <= total_r + TOT_W'(usage_r);
          held_r  <= held_r + 1'b1;
        end
        pos_r <= (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
      end
      if (cmd.result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      reading_r <= reading;
      delta_r   <= reading - baseline_r;
    end
    if (cmd.store_baseline && !have_base_r) begin
      usage_r     <= '0;
      avg_r       <= '0;
      res_valid_r <= 1'b0;
    end
    if (cmd.usage_zero) begin
      usage_r     <= '0;
      res_valid_r <= 1'b1;
    end
    if (cmd.usage_load) begin
      usage_r     <= FS - div_q[USG_W-1:0];
      res_valid_r <= 1'b1;
    end
    if (cmd.avg_load) begin
      avg_r <= div_q[USG_W-1:0];
    end
    if (cmd.result_load) begin
      out_flag_r  <= res_valid_r;
      out_usage_r <= usage_r;
      out_peak_r  <= peak_r;
      out_avg_r   <= avg_r;
    end
  end

  // Sample ring: the oldest sample is read ahead at the current position.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring[pos_r] <= usage_r;
    end
    ring_rd_r <= ring[pos_r];
  end

  always_comb begin
    sts.have_baseline = have_base_r;
    sts.sat           = (delta_r >= TICK_W'(sat_lim));
    sts.div_busy      = div_busy;
    sts.div_done      = div_done;
    sts.out_busy      = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_flag   = out_flag_r;
  assign out_usage  = out_usage_r;
  assign out_peak   = out_peak_r;
  assign out_avg    = out_avg_r;

endmodule

>>> sv/uwm_ctrl.sv
module uwm_ctrl
  import uwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.store_baseline = 1'b1;
        if (!sts.have_baseline) begin
          state_nxt = ST_EMIT;
        end else if (sts.sat) begin
          cmd.usage_zero = 1'b1;
          state_nxt      = ST_UPDATE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_U;
        end
      end
      ST_DIV_U: begin
        if (sts.div_done) begin
          cmd.usage_load = 1'b1;
          state_nxt      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_START_A;
      end
      ST_START_A: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
        state_nxt     = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd.div_avg = 1'b1;
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.result_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
